// File: design/vtm_pkg.sv
// ----------------------------------------------------------------------------
// vtm_pkg
// Shared types, constants and curve tables for the variometer tone mapper.
// ----------------------------------------------------------------------------
package vtm_pkg;

  // Field widths
  localparam int SPEED_W     = 16;
  localparam int BASE_W      = 12;
  localparam int STEP_W      = 10;
  localparam int TONE_W      = 11;
  localparam int BEEP_W      = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIFT_BASE   = 3'd0,
    REG_LIFT_STEP   = 3'd1,
    REG_SINK_BASE   = 3'd2,
    REG_SINK_STEP   = 3'd3,
    REG_CLIMB_LIMIT = 3'd4,
    REG_SINK_LIMIT  = 3'd5
  } reg_idx_t;

  // Register reset values
  localparam logic [BASE_W-1:0]         LIFT_BASE_RST   = 12'd1000;
  localparam logic [STEP_W-1:0]         LIFT_STEP_RST   = 10'd100;
  localparam logic [BASE_W-1:0]         SINK_BASE_RST   = 12'd500;
  localparam logic [STEP_W-1:0]         SINK_STEP_RST   = 10'd100;
  localparam logic signed [SPEED_W-1:0] CLIMB_LIMIT_RST = 16'sd100;
  localparam logic signed [SPEED_W-1:0] SINK_LIMIT_RST  = -16'sd2000;

  // Vario mode
  typedef enum logic [1:0] {
    MODE_QUIET = 2'd0,
    MODE_CLIMB = 2'd1,
    MODE_SINK  = 2'd2
  } mode_t;

  // Tone math: n = 1000*base + step*v in milli-hertz, clamped, then /1000 rounded
  localparam int TONE_ACC_W = 27;   // signed range of 1000*base + step*v
  localparam int TONE_N_W   = 21;   // clamped n, at most 2,000,000
  localparam int TONE_SCALE = 1000;
  localparam int TONE_HALF  = 500;
  localparam int LIFT_N_LO  = 500000;
  localparam int LIFT_N_HI  = 2000000;
  localparam int SINK_N_LO  = 250000;
  localparam int SINK_N_HI  = 1000000;

  // floor(t/1000) == (t*TONE_RECIP) >> TONE_SHIFT for t < 2**TONE_N_W
  localparam int TONE_SHIFT   = 31;
  localparam int TONE_RECIP_W = 22;
  localparam logic [TONE_RECIP_W-1:0] TONE_RECIP =
    TONE_RECIP_W'(((64'd1 << TONE_SHIFT) + 64'(TONE_SCALE) - 64'd1) / 64'(TONE_SCALE));

  // Beep curve: x in mm/s, y in 1/10000
  localparam int CURVE_POINTS = 6;
  localparam int SEG_COUNT    = CURVE_POINTS - 1;
  localparam int SEG_IDX_W    = $clog2(SEG_COUNT);
  localparam int CURVE_X_W    = 12;

  localparam int CURVE_X [CURVE_POINTS] = '{135, 441, 1029, 1559, 2471, 3571};
  localparam int CURVE_Y [CURVE_POINTS] = '{4755, 3619, 2238, 1565, 985, 741};

  // beep_ms = floor(X / (50*dx)) with X = dx*(6*y0 + 25) + 6*dy*(x - x0)
  localparam int BEEP_ACC_W  = 27;  // signed working width of X
  localparam int BEEP_X_W    = 24;  // X is positive and below 2**24
  localparam int BEEP_SHIFT  = 40;
  localparam int BEEP_RECIP_W = 27;

  typedef logic signed [BEEP_ACC_W-1:0] seg_word_arr_t [SEG_COUNT];
  typedef logic [BEEP_RECIP_W-1:0]      seg_recip_arr_t [SEG_COUNT];

  function automatic seg_word_arr_t calc_seg_base();
    seg_word_arr_t r;
    for (int i = 0; i < SEG_COUNT; i++) begin
      r[i] = BEEP_ACC_W'((CURVE_X[i+1] - CURVE_X[i]) * (6 * CURVE_Y[i] + 25));
    end
    return r;
  endfunction

  function automatic seg_word_arr_t calc_seg_slope6();
    seg_word_arr_t r;
    for (int i = 0; i < SEG_COUNT; i++) begin
      r[i] = BEEP_ACC_W'(6 * (CURVE_Y[i+1] - CURVE_Y[i]));
    end
    return r;
  endfunction

  localparam seg_word_arr_t SEG_BASE   = calc_seg_base();
  localparam seg_word_arr_t SEG_SLOPE6 = calc_seg_slope6();

  // Divisor 50*dx of each segment
  localparam longint SEG_DEN [SEG_COUNT] = '{
    50 * (CURVE_X[1] - CURVE_X[0]),
    50 * (CURVE_X[2] - CURVE_X[1]),
    50 * (CURVE_X[3] - CURVE_X[2]),
    50 * (CURVE_X[4] - CURVE_X[3]),
    50 * (CURVE_X[5] - CURVE_X[4])
  };

  // Rounded-up reciprocals, exact floor for X < 2**24 and divisor < 2**16
  localparam seg_recip_arr_t SEG_RECIP = '{
    BEEP_RECIP_W'(((64'd1 << BEEP_SHIFT) + SEG_DEN[0] - 1) / SEG_DEN[0]),
    BEEP_RECIP_W'(((64'd1 << BEEP_SHIFT) + SEG_DEN[1] - 1) / SEG_DEN[1]),
    BEEP_RECIP_W'(((64'd1 << BEEP_SHIFT) + SEG_DEN[2] - 1) / SEG_DEN[2]),
    BEEP_RECIP_W'(((64'd1 << BEEP_SHIFT) + SEG_DEN[3] - 1) / SEG_DEN[3]),
    BEEP_RECIP_W'(((64'd1 << BEEP_SHIFT) + SEG_DEN[4] - 1) / SEG_DEN[4])
  };

  // Channel payloads
  typedef struct packed {
    logic signed [SPEED_W-1:0] vertical_speed;
  } in_item_t;

  typedef struct packed {
    logic              climbing;
    logic              sinking;
    logic              beeping;
    logic [TONE_W-1:0] tone_hz;
    logic [BEEP_W-1:0] beep_ms;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_item_t;

endpackage

// File: design/vtm_chan_if.sv
// ----------------------------------------------------------------------------
// vtm_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface vtm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/variometer_tone_mapper.sv
// ----------------------------------------------------------------------------
// variometer_tone_mapper
// Vertical speed to climb/sink mode, tone frequency and beep length.
// ----------------------------------------------------------------------------
// Pipeline: an item is registered in the input reg, the stage 2 reg and the
//   result reg in turn before it is valid on out_ch.
// Throughput: one item per cycle unless out_ch stalls; the tone path (multiply-add
//   and clamp, then a reciprocal multiply for the divide by 1000) sets the stage split.
// Reset: synchronous, active low; pipeline emptied, mode quiet, registers at
//   their defaults. No clearing pass, first item accepted right after reset.
// ----------------------------------------------------------------------------
module variometer_tone_mapper (
  input  logic              clk,
  input  logic              rst_n,
  vtm_chan_if.sink          in_ch,
  vtm_chan_if.source        out_ch,
  vtm_chan_if.sink          cfg_ch
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [vtm_pkg::BASE_W-1:0]         lift_base_r;
  logic [vtm_pkg::STEP_W-1:0]         lift_step_r;
  logic [vtm_pkg::BASE_W-1:0]         sink_base_r;
  logic [vtm_pkg::STEP_W-1:0]         sink_step_r;
  logic signed [vtm_pkg::SPEED_W-1:0] climb_limit_r;
  logic signed [vtm_pkg::SPEED_W-1:0] sink_limit_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lift_base_r   <= vtm_pkg::LIFT_BASE_RST;
      lift_step_r   <= vtm_pkg::LIFT_STEP_RST;
      sink_base_r   <= vtm_pkg::SINK_BASE_RST;
      sink_step_r   <= vtm_pkg::SINK_STEP_RST;
      climb_limit_r <= vtm_pkg::CLIMB_LIMIT_RST;
      sink_limit_r  <= vtm_pkg::SINK_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      // Indexes past the list are dropped
      unique case (vtm_pkg::reg_idx_t'(cfg_ch.data.index))
        vtm_pkg::REG_LIFT_BASE:   lift_base_r   <= cfg_ch.data.value[vtm_pkg::BASE_W-1:0];
        vtm_pkg::REG_LIFT_STEP:   lift_step_r   <= cfg_ch.data.value[vtm_pkg::STEP_W-1:0];
        vtm_pkg::REG_SINK_BASE:   sink_base_r   <= cfg_ch.data.value[vtm_pkg::BASE_W-1:0];
        vtm_pkg::REG_SINK_STEP:   sink_step_r   <= cfg_ch.data.value[vtm_pkg::STEP_W-1:0];
        vtm_pkg::REG_CLIMB_LIMIT: climb_limit_r <= signed'(cfg_ch.data.value);
        vtm_pkg::REG_SINK_LIMIT:  sink_limit_r  <= signed'(cfg_ch.data.value);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: s1 (input reg) -> s2 -> out reg.
  // Each stage loads when empty or when its downstream takes its item.
  // --------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic out_load, s2_load, s1_load;

  assign out_load    = !out_valid_r || out_ch.ready;
  assign s2_load     = !s2_valid_r || out_load;
  assign s1_load     = !s1_valid_r || s2_load;
  assign in_ch.ready = s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load)  s1_valid_r  <= in_ch.valid;
      if (s2_load)  s2_valid_r  <= s1_valid_r;
      if (out_load) out_valid_r <= s2_valid_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic signed [vtm_pkg::SPEED_W-1:0] s1_speed_r;

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_speed_r <= in_ch.data.vertical_speed;
    end
  end

  // --------------------------------------------------------------------------
  // Mode: updated in item order as each item leaves s1
  // --------------------------------------------------------------------------
  vtm_pkg::mode_t mode_r, mode_nxt;
  logic           mode_adv;

  assign mode_adv = s1_valid_r && s2_load;

  // Order matters: a sample on a limit falls through and keeps the mode
  always_comb begin
    mode_nxt = mode_r;
    priority if (s1_speed_r > climb_limit_r) begin
      mode_nxt = vtm_pkg::MODE_CLIMB;
    end else if (s1_speed_r < climb_limit_r && s1_speed_r > sink_limit_r) begin
      mode_nxt = vtm_pkg::MODE_QUIET;
    end else if (s1_speed_r < sink_limit_r) begin
      mode_nxt = vtm_pkg::MODE_SINK;
    end else begin
      mode_nxt = mode_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= vtm_pkg::MODE_QUIET;
    end else if (mode_adv) begin
      mode_r <= mode_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 tone: n = 1000*base + step*v, clamped to the band of each tone
  // --------------------------------------------------------------------------
  localparam int AW = vtm_pkg::TONE_ACC_W;
  localparam int NW = vtm_pkg::TONE_N_W;

  logic signed [AW-1:0] speed_ext;
  logic signed [AW-1:0] lift_n, sink_n;
  logic [NW-1:0]        lift_clamp, sink_clamp, tone_n;

  assign speed_ext = AW'(s1_speed_r);

  always_comb begin
    lift_n = signed'(AW'(lift_base_r)) * AW'(vtm_pkg::TONE_SCALE)
           + signed'(AW'(lift_step_r)) * speed_ext;
    sink_n = signed'(AW'(sink_base_r)) * AW'(vtm_pkg::TONE_SCALE)
           + signed'(AW'(sink_step_r)) * speed_ext;
  end

  always_comb begin
    priority if (lift_n < AW'(vtm_pkg::LIFT_N_LO)) begin
      lift_clamp = NW'(vtm_pkg::LIFT_N_LO);
    end else if (lift_n > AW'(vtm_pkg::LIFT_N_HI)) begin
      lift_clamp = NW'(vtm_pkg::LIFT_N_HI);
    end else begin
      lift_clamp = lift_n[NW-1:0];
    end

    priority if (sink_n < AW'(vtm_pkg::SINK_N_LO)) begin
      sink_clamp = NW'(vtm_pkg::SINK_N_LO);
    end else if (sink_n > AW'(vtm_pkg::SINK_N_HI)) begin
      sink_clamp = NW'(vtm_pkg::SINK_N_HI);
    end else begin
      sink_clamp = sink_n[NW-1:0];
    end
  end

  // Lift tone also in quiet mode
  assign tone_n = (mode_nxt == vtm_pkg::MODE_SINK) ? sink_clamp : lift_clamp;

  // --------------------------------------------------------------------------
  // Stage 1 beep: clamp speed to the curve, pick the segment, build numerator
  // --------------------------------------------------------------------------
  localparam int XW = vtm_pkg::CURVE_X_W;
  localparam int BW = vtm_pkg::BEEP_ACC_W;
  localparam int SW = vtm_pkg::SEG_IDX_W;

  logic [XW-1:0]        curve_v;
  logic [XW-1:0]        seg_off;
  logic [SW-1:0]        seg;
  logic signed [BW-1:0] beep_acc;

  always_comb begin
    priority if (s1_speed_r <= vtm_pkg::SPEED_W'(vtm_pkg::CURVE_X[0])) begin
      curve_v = XW'(vtm_pkg::CURVE_X[0]);
    end else if (s1_speed_r >=
                 vtm_pkg::SPEED_W'(vtm_pkg::CURVE_X[vtm_pkg::CURVE_POINTS-1])) begin
      curve_v = XW'(vtm_pkg::CURVE_X[vtm_pkg::CURVE_POINTS-1]);
    end else begin
      curve_v = s1_speed_r[XW-1:0];
    end
  end

  // Last segment also covers the end point itself
  always_comb begin
    seg = SW'(vtm_pkg::SEG_COUNT - 1);
    for (int i = vtm_pkg::SEG_COUNT - 2; i >= 0; i--) begin
      if (curve_v < XW'(vtm_pkg::CURVE_X[i+1])) seg = SW'(i);
    end
  end

  assign seg_off  = curve_v - XW'(vtm_pkg::CURVE_X[seg]);
  assign beep_acc = vtm_pkg::SEG_BASE[seg] + vtm_pkg::SEG_SLOPE6[seg] * signed'(BW'(seg_off));

  // --------------------------------------------------------------------------
  // Stage 2 registers
  // --------------------------------------------------------------------------
  vtm_pkg::mode_t                s2_mode_r;
  logic [NW-1:0]                 s2_tone_n_r;
  logic [vtm_pkg::BEEP_X_W-1:0]  s2_beep_x_r;
  logic [SW-1:0]                 s2_seg_r;

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_mode_r   <= mode_nxt;
      s2_tone_n_r <= tone_n;
      s2_beep_x_r <= beep_acc[vtm_pkg::BEEP_X_W-1:0];
      s2_seg_r    <= seg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2 divides by reciprocal multiply: tone (n+500)/1000, beep X/(50*dx)
  // --------------------------------------------------------------------------
  localparam int TPW = NW + vtm_pkg::TONE_RECIP_W;
  localparam int BPW = vtm_pkg::BEEP_X_W + vtm_pkg::BEEP_RECIP_W;

  logic [NW-1:0]  tone_round;
  logic [TPW-1:0] tone_prod;
  logic [BPW-1:0] beep_prod;

  assign tone_round = s2_tone_n_r + NW'(vtm_pkg::TONE_HALF);
  assign tone_prod  = TPW'(tone_round) * TPW'(vtm_pkg::TONE_RECIP);
  assign beep_prod  = BPW'(s2_beep_x_r) * BPW'(vtm_pkg::SEG_RECIP[s2_seg_r]);

  vtm_pkg::out_item_t out_nxt;

  always_comb begin
    out_nxt.climbing = (s2_mode_r == vtm_pkg::MODE_CLIMB);
    out_nxt.sinking  = (s2_mode_r == vtm_pkg::MODE_SINK);
    out_nxt.beeping  = (s2_mode_r != vtm_pkg::MODE_QUIET);
    out_nxt.tone_hz  = tone_prod[vtm_pkg::TONE_SHIFT +: vtm_pkg::TONE_W];
    out_nxt.beep_ms  = beep_prod[vtm_pkg::BEEP_SHIFT +: vtm_pkg::BEEP_W];
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  vtm_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// File: design/vtm_checker.sv
// ----------------------------------------------------------------------------
// vtm_checker
// Port-level checks of the variometer tone mapper, bound to the top level.
// ----------------------------------------------------------------------------
module vtm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input vtm_pkg::out_item_t out_data
);

  // Climb and sink are exclusive, beep follows them
  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.climbing && out_data.sinking)
                  && (out_data.beeping == (out_data.climbing || out_data.sinking)))
    else $error("mode flags inconsistent");

  // Tone inside the band of the active tone
  a_tone_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sinking
                   ? (out_data.tone_hz >= 11'd250 && out_data.tone_hz <= 11'd1000)
                   : (out_data.tone_hz >= 11'd500 && out_data.tone_hz <= 11'd2000)))
    else $error("tone out of band");

  // Beep length between the curve end values
  a_beep_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.beep_ms >= 10'd89 && out_data.beep_ms <= 10'd571))
    else $error("beep length out of range");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind variometer_tone_mapper vtm_checker u_vtm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
